FILE: hdl/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and constants for the base64url stream encoder
// group record passed from the byte collector to the character emitter
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] DASH_CHAR  = 8'h2D;  // '-'
  localparam logic [7:0] UNDER_CHAR = 8'h5F;  // '_'

  // number of alphabet characters in a group (2, 3 or 4), rest is padding
  localparam logic [2:0] USED_ONE   = 3'd2;
  localparam logic [2:0] USED_TWO   = 3'd3;
  localparam logic [2:0] USED_THREE = 3'd4;

  typedef struct packed {
    logic [23:0] bytes;   // first byte in the top bits, missing bytes zero
    logic [2:0]  used;    // alphabet characters before padding
    logic        last;    // group closes the message
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // url-safe alphabet lookup
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;         // 'a' - 26
    end else if (v < 6'd62) begin
      c = w - 8'd4;          // '0' - 52
    end else if (v == 6'd62) begin
      c = DASH_CHAR;
    end else begin
      c = UNDER_CHAR;
    end
    return c;
  endfunction

endpackage

FILE: hdl/base64url_stream_encoder_top.sv
`timescale 1ns / 1ps
// a group's closing byte passes the group queue, cur_r, then the output register
// throughput: one character per cycle unless out_tready holds the output back
// the emitter walking four character slots per group sets the sustained rate
// input takes a byte every cycle while the group queue has room
// reset: synchronous active-low rst_n clears held bytes, queue and output valid
// ----------------------------------------------------------------------------
// base64url_stream_encoder_top: base64url encoder with '=' padding
// byte collector, group queue and character emitter on stream channels
// ----------------------------------------------------------------------------
module base64url_stream_encoder_top #(
  parameter int QUEUE_DEPTH = 2   // group records buffered, at least 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte requests
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,    // last_byte
  // character requests
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_char
  output logic       out_tlast    // last_char
);

  b64u_pkg::grp_t    q_wdata;
  b64u_pkg::grp_t    q_rdata;
  b64u_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;

  // front: collects bytes, a group closes on the third byte or on the last one
  b64u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // queue decouples byte intake from character output
  b64u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: four characters per group, alphabet then padding, tlast on a last group
  b64u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a last byte always closes a group in the same cycle
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> q_push)
    else $error("last byte did not close a group");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("group queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("group queue underflow");

endmodule

FILE: hdl/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_front: byte collector
// holds up to two bytes and pushes a group record when a group closes
// ----------------------------------------------------------------------------
module b64u_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // last_byte
  input  b64u_pkg::q_stat_t q_stat,
  output logic              q_push,
  output b64u_pkg::grp_t    q_wdata
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        accept;
  logic        close;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held_nxt = held_r;
    fill_nxt = fill_r;
    close    = 1'b1;
    q_wdata.last = in_tlast;
    case (fill_r)
      2'd0: begin
        q_wdata.bytes = {in_tdata, 16'h0000};
        q_wdata.used  = b64u_pkg::USED_ONE;
        close         = in_tlast;
        if (accept && !in_tlast) begin
          held_nxt = {in_tdata, 8'h00};
          fill_nxt = 2'd1;
        end
      end
      2'd1: begin
        q_wdata.bytes = {held_r[15:8], in_tdata, 8'h00};
        q_wdata.used  = b64u_pkg::USED_TWO;
        close         = in_tlast;
        if (accept && !in_tlast) begin
          held_nxt = {held_r[15:8], in_tdata};
          fill_nxt = 2'd2;
        end
      end
      default: begin
        q_wdata.bytes = {held_r, in_tdata};
        q_wdata.used  = b64u_pkg::USED_THREE;
      end
    endcase
    if (accept && close) begin
      held_nxt = 16'h0000;
      fill_nxt = 2'd0;
    end
  end

  assign q_push = accept && close;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      fill_r <= 2'd0;
    end else begin
      held_r <= held_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: hdl/b64u_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_fifo: group queue
// short register queue between collector and emitter
// ----------------------------------------------------------------------------
module b64u_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64u_pkg::grp_t    wdata,
  input  logic              pop,
  output b64u_pkg::grp_t    rdata,
  output b64u_pkg::q_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64u_pkg::grp_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_back: character emitter
// walks one group through its four character slots into a registered output stage
// ----------------------------------------------------------------------------
module b64u_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64u_pkg::q_stat_t q_stat,
  input  b64u_pkg::grp_t    q_rdata,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_char
  output logic              out_tlast   // last_char
);

  b64u_pkg::grp_t cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_free;
  logic       load;
  logic       fin;
  logic [5:0] sextet;
  logic [7:0] chr;

  assign out_free = !out_valid_r || out_tready;
  assign load     = cur_valid_r && out_free;
  assign fin      = load && (k_r == 2'd3);
  assign q_pop    = !q_stat.empty && (!cur_valid_r || fin);

  always_comb begin
    case (k_r)
      2'd0:    sextet = cur_r.bytes[23:18];
      2'd1:    sextet = cur_r.bytes[17:12];
      2'd2:    sextet = cur_r.bytes[11:6];
      default: sextet = cur_r.bytes[5:0];
    endcase
    chr = ({1'b0, k_r} < cur_r.used) ? b64u_pkg::sextet_char(sextet)
                                     : b64u_pkg::PAD_CHAR;
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    k_nxt         = k_r;
    if (load) begin
      k_nxt = k_r + 2'd1;
    end
    if (fin) begin
      cur_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      k_nxt         = 2'd0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (load) begin
      out_data_r <= chr;
      out_last_r <= cur_r.last && (k_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
